### rtl/core/sbm_pkg.sv
// Shared types, widths and helpers for the sliding bit mismatch rate unit.
package sbm_pkg;

	// Default pattern depth
	localparam int PATTERN_MAX_DEF = 64;

	// Item field widths
	localparam int FUNC_W = 2;
	localparam int IDX_W  = 6;
	localparam int BYTE_W = 8;
	localparam int LEN_W  = 7;
	localparam int DIFF_W = 10;
	localparam int PCT_W  = 15;
	localparam int POS_W  = 32;

	// Stream bus widths
	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 64;

	// Percentage scale: 100 * 256 / 8
	localparam int PCT_SCALE   = 100 * 256 / 8;
	localparam int PCT_SCALE_W = 12;

	// Function codes carried in the input tuser
	typedef enum logic [FUNC_W-1:0] {
		FUNC_LOAD  = 2'd0,
		FUNC_PUSH  = 2'd1,
		FUNC_CLEAR = 2'd2,
		FUNC_NOP   = 2'd3
	} func_t;

	// Per-cycle commands for the cell row
	typedef struct packed {
		logic push;
		logic load;
		logic step;
	} cell_ctrl_t;

	// Count set bits of one byte
	function automatic logic [3:0] popcount8(input logic [BYTE_W-1:0] v);
		logic [3:0] n;
		n = '0;
		for (int b = 0; b < BYTE_W; b++) begin
			n = n + {3'b000, v[b]};
		end
		return n;
	endfunction

endpackage

### rtl/core/sliding_bit_mismatch_rate_unit.sv
// Top level of the sliding bit mismatch rate unit.
//
// Channel   Signals                        Contents (low bit first)
// s_axis    s_tvalid s_tready s_tdata s_tuser  tuser: func; tdata: pattern_index, data_byte
// m_axis    m_tvalid m_tready m_tdata       tdata: diff_bits, percent_q8, window_start
// config    cfg_we cfg_wdata               pattern_len, written on any cycle with cfg_we
//
// Pattern loads, clears, no-ops and pushes that leave the window short are handled without
// leaving the idle state. A push that completes a window goes through the accept, the scan
// through the cell row against the pattern memory, the multiply, the divider steps and the
// check for done, and the hand-off to the output register.
// The output register holds one result; a new item is taken while it waits for m_tready, and
// the next finished result holds the input stalled until the waiting one is taken.
// Reset clears the fill count, the position, the state and the output valid; the pattern
// and the window contents stay undefined until written.
module sliding_bit_mismatch_rate_unit #(
	parameter int PATTERN_MAX = sbm_pkg::PATTERN_MAX_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [sbm_pkg::S_TDATA_W-1:0]  s_tdata,  // pattern_index, data_byte, zero pad
	input  logic [sbm_pkg::FUNC_W-1:0]     s_tuser,  // func
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [sbm_pkg::M_TDATA_W-1:0]  m_tdata,  // diff_bits, percent_q8, window_start, pad
	input  logic                           cfg_we,
	input  logic [sbm_pkg::LEN_W-1:0]      cfg_wdata // pattern_len
);
	import sbm_pkg::*;

	localparam int AW    = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
	localparam int LW    = $clog2(PATTERN_MAX + 1);
	localparam int XW    = (AW > IDX_W) ? AW : IDX_W;
	localparam int ACC_W = $clog2(8 * PATTERN_MAX + 1);
	localparam int NUM_W = ACC_W + PCT_SCALE_W;
	localparam int OUT_W = DIFF_W + PCT_W + POS_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_MUL,
		S_DIV,
		S_DONE
	} state_t;

	state_t            state_q;
	logic [LEN_W-1:0]  pattern_len_q;
	logic [LW-1:0]     fill_q;
	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  start_q;
	logic [LW-1:0]     cnt_q;
	logic [AW-1:0]     rd_addr_q;
	logic [ACC_W-1:0]  acc_q;
	logic              m_tvalid_q;
	logic [OUT_W-1:0]  out_q;

	logic [IDX_W-1:0]  pattern_index;
	logic [BYTE_W-1:0] data_byte;
	func_t             func;
	logic              accept;
	logic              acc_load;
	logic              acc_push;
	logic              acc_clear;
	logic [XW-1:0]     idx_x;
	logic              idx_ok;
	logic [LW-1:0]     len_eff;
	logic [LW-1:0]     fill_nx;
	logic              full;
	logic [AW-1:0]     rd_addr;
	logic [BYTE_W-1:0] pat_byte;
	cell_ctrl_t        cell_ctrl;
	logic [BYTE_W-1:0] win_chain  [PATTERN_MAX];
	logic [BYTE_W-1:0] scan_chain [PATTERN_MAX];
	logic              div_start;
	logic              div_done;
	logic [NUM_W-1:0]  div_num;
	logic [NUM_W-1:0]  div_quot;

	// Unpack the input item
	assign pattern_index = s_tdata[IDX_W-1:0];
	assign data_byte     = s_tdata[IDX_W+BYTE_W-1:IDX_W];
	assign func          = func_t'(s_tuser);

	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign acc_load  = accept && (func == FUNC_LOAD);
	assign acc_push  = accept && (func == FUNC_PUSH);
	assign acc_clear = accept && (func == FUNC_CLEAR);

	// Drop pattern writes past the store depth
	assign idx_x  = XW'(pattern_index);
	assign idx_ok = ({1'b0, idx_x} < (XW+1)'(PATTERN_MAX));

	// Clamp the configured length into 1..PATTERN_MAX
	always_comb begin
		if (pattern_len_q == '0) begin
			len_eff = LW'(1);
		end else if (int'(pattern_len_q) > PATTERN_MAX) begin
			len_eff = LW'(PATTERN_MAX);
		end else begin
			len_eff = LW'(pattern_len_q);
		end
	end

	// Saturating fill after this push
	assign fill_nx = (fill_q == LW'(PATTERN_MAX)) ? fill_q : (fill_q + LW'(1));
	assign full    = (fill_nx >= len_eff);

	// Pattern is read from the top index down while the scan bytes come oldest-last
	assign rd_addr = (state_q == S_SCAN) ? rd_addr_q : AW'(len_eff - LW'(1));

	sbm_pattern_mem #(
		.DEPTH (PATTERN_MAX),
		.AW    (AW)
	) u_pattern_mem (
		.clk   (clk),
		.we    (acc_load && idx_ok),
		.waddr (idx_x[AW-1:0]),
		.wdata (data_byte),
		.raddr (rd_addr),
		.rdata (pat_byte)
	);

	// Cell row commands
	assign cell_ctrl.push = acc_push;
	assign cell_ctrl.load = acc_push && full;
	assign cell_ctrl.step = (state_q == S_SCAN);

	// Row of window cells: window moves up, scan bytes move down to cell zero
	for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
		logic [BYTE_W-1:0] win_in;
		logic [BYTE_W-1:0] scan_in;

		if (k == 0) begin : g_head
			assign win_in = data_byte;
		end else begin : g_body
			assign win_in = win_chain[k-1];
		end

		if (k == PATTERN_MAX - 1) begin : g_tail
			assign scan_in = '0;
		end else begin : g_next
			assign scan_in = scan_chain[k+1];
		end

		sbm_cell u_cell (
			.clk      (clk),
			.ctrl     (cell_ctrl),
			.win_in   (win_in),
			.scan_in  (scan_in),
			.win_out  (win_chain[k]),
			.scan_out (scan_chain[k])
		);
	end

	// Scale the count for the percentage
	assign div_start = (state_q == S_MUL);
	assign div_num   = NUM_W'(acc_q) * NUM_W'(PCT_SCALE);

	sbm_divider #(
		.NUM_W (NUM_W),
		.DEN_W (LW)
	) u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (len_eff),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_len_q <= LEN_W'(1);
		end else if (cfg_we) begin
			pattern_len_q <= cfg_wdata;
		end
	end

	// Sequencer, fill count, position and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			fill_q     <= '0;
			pos_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if ((state_q == S_DONE) && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc_clear) begin
						fill_q <= '0;
						pos_q  <= '0;
					end else if (acc_push) begin
						fill_q <= fill_nx;
						pos_q  <= pos_q + POS_W'(1);
						if (full) begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (cnt_q == LW'(1)) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Scan datapath: accumulate differing bits one byte per cycle
	always_ff @(posedge clk) begin
		if (acc_push && full) begin
			start_q   <= pos_q + POS_W'(1) - POS_W'(len_eff);
			cnt_q     <= len_eff;
			acc_q     <= '0;
			rd_addr_q <= AW'(len_eff - LW'(2));
		end else if (state_q == S_SCAN) begin
			cnt_q     <= cnt_q - LW'(1);
			acc_q     <= acc_q + ACC_W'(popcount8(scan_chain[0] ^ pat_byte));
			rd_addr_q <= rd_addr_q - AW'(1);
		end
	end

	// Hold the finished result
	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && (!m_tvalid_q || m_tready)) begin
			out_q <= {start_q, PCT_W'(div_quot), DIFF_W'(acc_q)};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_TDATA_W'(out_q);

	a_full_push_scans: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_push && full) |=> (state_q == S_SCAN))
		else $error("full window push did not start a scan");

	a_scan_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (cnt_q != '0))
		else $error("scan running with zero bytes left");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider finished outside the divide state");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= LW'(PATTERN_MAX))
		else $error("fill count beyond pattern depth");

endmodule

### rtl/core/sbm_cell.sv
// One cell of the window row: a window byte and a scan byte.
module sbm_cell (
	input  logic                        clk,
	input  sbm_pkg::cell_ctrl_t         ctrl,
	input  logic [sbm_pkg::BYTE_W-1:0]  win_in,
	input  logic [sbm_pkg::BYTE_W-1:0]  scan_in,
	output logic [sbm_pkg::BYTE_W-1:0]  win_out,
	output logic [sbm_pkg::BYTE_W-1:0]  scan_out
);
	import sbm_pkg::*;

	logic [BYTE_W-1:0] win_q;
	logic [BYTE_W-1:0] scan_q;

	// Advance the window toward older positions on a push
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			win_q <= win_in;
		end
	end

	// Snapshot the shifted window, then hand scan bytes toward cell zero
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			scan_q <= win_in;
		end else if (ctrl.step) begin
			scan_q <= scan_in;
		end
	end

	assign win_out  = win_q;
	assign scan_out = scan_q;

endmodule

### rtl/core/sbm_pattern_mem.sv
// Pattern byte store: one write port, one registered read port.
module sbm_pattern_mem #(
	parameter int DEPTH = sbm_pkg::PATTERN_MAX_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [sbm_pkg::BYTE_W-1:0]  wdata,
	input  logic [AW-1:0]               raddr,
	output logic [sbm_pkg::BYTE_W-1:0]  rdata
);
	import sbm_pkg::*;

	logic [BYTE_W-1:0] mem_q [DEPTH];
	logic [BYTE_W-1:0] rdata_q;

	// Write one pattern byte
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read every cycle
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/sbm_divider.sv
// Restoring divider, one quotient bit per cycle.
module sbm_divider #(
	parameter int NUM_W = 21,
	parameter int DEN_W = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);
	localparam int CW = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   rem_q;
	logic [DEN_W:0]   rem_sh;
	logic             ge;

	// Bring down the next dividend bit and try the subtract
	assign rem_sh = {rem_q[DEN_W-1:0], num_q[NUM_W-1]};
	assign ge     = (rem_sh >= {1'b0, den_q});

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: quotient bits shift in behind the dividend
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
			num_q <= {num_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = num_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (rem_q < {1'b0, den_q}))
		else $error("partial remainder not below divisor");

	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> done_q)
		else $error("divider stopped without done");

endmodule
